// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the normalizer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clock edge outside reset.
`define VN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that post holds in the cycle after pre.
`define VN_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  `VN_ASSERT(lbl, clk, rstn, (pre) |=> (post), msg)

`endif

// ===== hw/rtl/vn_pkg.sv =====
// Shared widths and payload types of the 2-D vector normalizer.
// No dependencies.
`default_nettype none

package vn_pkg;

  localparam int COMP_WIDTH = 16;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] x_in;
    logic signed [COMP_WIDTH-1:0] y_in;
  } vn_in_t;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] x_unit;
    logic signed [COMP_WIDTH-1:0] y_unit;
    logic                         zero_vector;
  } vn_out_t;

  // Per-beat sideband that travels alongside the datapath.
  typedef struct packed {
    logic vld;
    logic nx;
    logic ny;
    logic zero;
  } vn_side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vn_lane.sv =====
// One component lane: k = isqrt(floor(sq * 2^(2W) / s)), one bit per stage.
// Depends on vn_pkg for the component width.
`default_nettype none

module vn_lane (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [2*vn_pkg::COMP_WIDTH-1:0]   sq_i,
  input  wire logic [2*vn_pkg::COMP_WIDTH-1:0]   s_i,
  output logic      [vn_pkg::COMP_WIDTH:0]       root_o
);

  localparam int W  = vn_pkg::COMP_WIDTH;
  localparam int DW = 2 * W;
  localparam int QW = 2 * W + 1;
  localparam int KW = W + 1;
  localparam int RW = W + 3;

  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] s_r   [QW];
  logic [QW-1:0] q_r   [QW];

  logic [QW-1:0] qk_r  [KW-1];
  logic [RW-1:0] sr_r  [KW];
  logic [KW-1:0] rt_r  [KW];

  // Restoring division, quotient bit 2W-d at stage d.
  for (genvar d = 0; d < QW; d++) begin : g_div
    logic [QW-1:0] cur;
    logic [DW-1:0] s_src;
    logic [QW-1:0] q_prev;
    logic [QW-1:0] diff;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    if (d == 0) begin : g_first
      assign cur    = {1'b0, sq_i};
      assign s_src  = s_i;
      assign q_prev = '0;
    end else begin : g_rest
      assign cur    = {rem_r[d-1], 1'b0};
      assign s_src  = s_r[d-1];
      assign q_prev = q_r[d-1];
    end

    always_comb begin
      ge      = cur >= {1'b0, s_src};
      diff    = cur - {1'b0, s_src};
      rem_nxt = ge ? diff[DW-1:0] : cur[DW-1:0];
      q_nxt   = {q_prev[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[d] <= rem_nxt;
        s_r[d]   <= s_src;
        q_r[d]   <= q_nxt;
      end
    end
  end

  // Digit-by-digit square root, two radicand bits per stage.
  for (genvar j = 0; j < KW; j++) begin : g_sqrt
    localparam int I = W - j;
    logic [QW-1:0] qv;
    logic [QW:0]   qpad;
    logic [RW-1:0] rem_prev;
    logic [KW-1:0] root_prev;
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic          ge;
    logic [RW-1:0] sr_nxt;
    logic [KW-1:0] rt_nxt;

    if (j == 0) begin : g_first
      assign qv        = q_r[QW-1];
      assign rem_prev  = '0;
      assign root_prev = '0;
    end else begin : g_rest
      assign qv        = qk_r[j-1];
      assign rem_prev  = sr_r[j-1];
      assign root_prev = rt_r[j-1];
    end

    always_comb begin
      qpad   = {1'b0, qv};
      cur    = {rem_prev[RW-3:0], qpad[2*I+1:2*I]};
      trial  = {root_prev, 2'b01};
      ge     = cur >= trial;
      sr_nxt = ge ? cur - trial : cur;
      rt_nxt = {root_prev[KW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_r[j] <= sr_nxt;
        rt_r[j] <= rt_nxt;
      end
    end

    if (j < KW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          qk_r[j] <= qv;
        end
      end
    end
  end

  assign root_o = rt_r[KW-1];

endmodule

`default_nettype wire

// ===== hw/rtl/vector2_normalize_top.sv =====
// Top level of the 2-D vector normalizer: magnitude, squares, sum, two lanes.
// Depends on vn_pkg, vn_lane and assert_macros.svh.
//
//  channel | direction | payload         | handshake
//  in_     | input     | vn_pkg::vn_in_t | in_valid / in_ready
//  out_    | output    | vn_pkg::vn_out_t| out_valid / out_ready
//
// One beat enters per cycle while the output is not stalled; each beat passes the
// front stages, the bit-per-stage divider and square root in each lane, then the output register.
// Reset clears every valid bit; payload registers are not reset.
// A stalled output freezes the whole pipe, so in_ready follows out_ready
// whenever the output register holds a beat.
`default_nettype none

module vector2_normalize_top (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire vn_pkg::vn_in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output vn_pkg::vn_out_t      out_data
);

  localparam int W   = vn_pkg::COMP_WIDTH;
  localparam int LAT = 3 * W + 2;
  localparam int SBN = LAT + 3;

  logic en;

  vn_pkg::vn_side_t sb_r [SBN];
  logic [SBN-1:0]   vld_vec;

  logic [W-1:0]     ax_r, ay_r;
  logic [2*W-1:0]   sqx_r, sqy_r;
  logic [2*W-1:0]   sqx2_r, sqy2_r, s_r;

  logic [W:0]       kx, ky;
  logic             out_valid_r;
  vn_pkg::vn_out_t  out_r;
  vn_pkg::vn_out_t  out_nxt;
  vn_pkg::vn_side_t side_in;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    side_in.vld  = in_valid;
    side_in.nx   = in_data.x_in[W-1];
    side_in.ny   = in_data.y_in[W-1];
    side_in.zero = (in_data.x_in == '0) && (in_data.y_in == '0);
  end

  // Sideband shift line; drop its valid bits on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SBN; i++) begin
        sb_r[i].vld <= 1'b0;
      end
    end else if (en) begin
      sb_r[0] <= side_in;
      for (int i = 1; i < SBN; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SBN; i++) begin
      vld_vec[i] = sb_r[i].vld;
    end
  end

  // Front stages: magnitude, squares, sum of squares.
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r   <= in_data.x_in[W-1] ? W'(-in_data.x_in) : W'(in_data.x_in);
      ay_r   <= in_data.y_in[W-1] ? W'(-in_data.y_in) : W'(in_data.y_in);
      sqx_r  <= (2*W)'(ax_r) * (2*W)'(ax_r);
      sqy_r  <= (2*W)'(ay_r) * (2*W)'(ay_r);
      sqx2_r <= sqx_r;
      sqy2_r <= sqy_r;
      s_r    <= sqx_r + sqy_r;
    end
  end

  vn_lane u_lane_x (
    .clk    (clk),
    .en     (en),
    .sq_i   (sqx2_r),
    .s_i    (s_r),
    .root_o (kx)
  );

  vn_lane u_lane_y (
    .clk    (clk),
    .en     (en),
    .sq_i   (sqy2_r),
    .s_i    (s_r),
    .root_o (ky)
  );

  // Round to nearest via (k+1)/2, saturate full scale, restore sign.
  function automatic logic [W-1:0] unit_field(input logic [W:0] k, input logic neg);
    logic [W+1:0] kp;
    logic [W:0]   n;
    logic [W-1:0] mag;
    kp  = {1'b0, k} + (W+2)'(1);
    n   = kp[W+1:1];
    mag = (n[W:W-1] != 2'b00) ? {1'b0, {(W-1){1'b1}}} : n[W-1:0];
    return neg ? W'(-mag) : mag;
  endfunction

  always_comb begin
    out_nxt.zero_vector = sb_r[SBN-1].zero;
    if (sb_r[SBN-1].zero) begin
      out_nxt.x_unit = '0;
      out_nxt.y_unit = '0;
    end else begin
      out_nxt.x_unit = unit_field(kx, sb_r[SBN-1].nx);
      out_nxt.y_unit = unit_field(ky, sb_r[SBN-1].ny);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sb_r[SBN-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "assert_macros.svh"

  `VN_ASSERT(a_zero_out, clk, rst_n, out_valid_r && out_r.zero_vector |-> out_r.x_unit == '0 && out_r.y_unit == '0, "zero vector with nonzero components")
  `VN_ASSERT(a_no_min, clk, rst_n, out_valid_r |-> out_r.x_unit != {1'b1, {(W-1){1'b0}}} && out_r.y_unit != {1'b1, {(W-1){1'b0}}}, "unsaturated full-scale result")
  `VN_ASSERT_NEXT(a_stall_hold, clk, rst_n, !en, $stable(vld_vec), "pipe moved during stall")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for vector2_normalize_top: directed corner vectors,
// then random traffic with idle gaps and a long output stall. Depends on vn_pkg.
`default_nettype none

class unit_vec_board;
  vn_pkg::vn_out_t pending[$];
  int fails;
  int matched;

  // Largest n with (2n-1)^2 * s <= a^2 * 2^(2W), capped below full scale.
  static function logic [15:0] unit_mag(logic [16:0] a, logic [33:0] s);
    logic [63:0] rhs;
    logic [63:0] lhs;
    logic [16:0] n;
    logic [16:0] cand;
    logic [17:0] odd;
    rhs = ({47'd0, a} * {47'd0, a}) << 32;
    n = '0;
    for (int b = 15; b >= 0; b--) begin
      cand = n | (17'd1 << b);
      odd = {cand, 1'b0} - 18'd1;
      lhs = {46'd0, odd} * {46'd0, odd} * {30'd0, s};
      if (lhs <= rhs) n = cand;
    end
    if (n > 17'd32767) n = 17'd32767;
    return n[15:0];
  endfunction

  function void note_vector(vn_pkg::vn_in_t v);
    vn_pkg::vn_out_t r;
    logic [16:0] ax;
    logic [16:0] ay;
    logic [33:0] s;
    logic [15:0] mx;
    logic [15:0] my;
    ax = v.x_in[15] ? 17'(-$signed({v.x_in[15], v.x_in})) : {1'b0, v.x_in};
    ay = v.y_in[15] ? 17'(-$signed({v.y_in[15], v.y_in})) : {1'b0, v.y_in};
    s = {17'd0, ax} * {17'd0, ax} + {17'd0, ay} * {17'd0, ay};
    if (s == 0) begin
      r.x_unit = '0;
      r.y_unit = '0;
      r.zero_vector = 1'b1;
    end else begin
      mx = unit_mag(ax, s);
      my = unit_mag(ay, s);
      r.x_unit = v.x_in[15] ? -mx : mx;
      r.y_unit = v.y_in[15] ? -my : my;
      r.zero_vector = 1'b0;
    end
    pending.push_back(r);
  endfunction

  function void check_unit(vn_pkg::vn_out_t got);
    vn_pkg::vn_out_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected beat x=%0d y=%0d z=%0b", $time,
               got.x_unit, got.y_unit, got.zero_vector);
      fails++;
      return;
    end
    want = pending.pop_front();
    matched++;
    if (got.x_unit !== want.x_unit) begin
      $display("%0t: x_unit expected %0d got %0d", $time, want.x_unit, got.x_unit);
      fails++;
    end
    if (got.y_unit !== want.y_unit) begin
      $display("%0t: y_unit expected %0d got %0d", $time, want.y_unit, got.y_unit);
      fails++;
    end
    if (got.zero_vector !== want.zero_vector) begin
      $display("%0t: zero_vector expected %0b got %0b", $time,
               want.zero_vector, got.zero_vector);
      fails++;
    end
  endfunction
endclass

module testbench;

  localparam int LATENCY = 55;
  localparam int NUM_RANDOM = 1500;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  vn_pkg::vn_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vn_pkg::vn_out_t out_data;

  unit_vec_board board = new();

  int idle_cycles = 0;
  int sent = 0;
  bit long_stall = 1'b0;

  vector2_normalize_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Offer one vector, hold it until accepted, then, if gaps is set, leave a random gap.
  task automatic send_vector(logic [15:0] x, logic [15:0] y, bit gaps);
    int g;
    in_valid <= 1'b1;
    in_data <= {x, y};
    do @(posedge clk); while (!in_ready);
    board.note_vector(in_data);
    sent++;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_comp();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 6)) - 3);
      3: return 16'(int'($urandom_range(0, 255)) - 128);
      default: return 16'($urandom());
    endcase
  endfunction

  // Sample results and check them; count idle cycles for the watchdog.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_unit(out_data);
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Receiver: random stalls, a ready window, one long hold-off that stalls the sender.
  initial begin
    int g;
    wait (rst_n);
    while (1) begin
      @(posedge clk);
      if (long_stall) begin
        out_ready <= 1'b0;
        for (int i = 0; i < 300; i++) @(posedge clk);
        long_stall = 1'b0;
        out_ready <= 1'b1;
      end else if (sent > 300 && sent < 700) begin
        out_ready <= 1'b1;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    while (1) begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG) begin
        $display("Timeout after %0d idle cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed corners: zero, axes, extremes, ties near diagonals.
    send_vector(16'd0, 16'd0, 0);
    send_vector(16'd1, 16'd0, 0);
    send_vector(16'd0, 16'hffff, 0);
    send_vector(16'h8000, 16'd0, 0);
    send_vector(16'd0, 16'h8000, 0);
    send_vector(16'h7fff, 16'd0, 0);
    send_vector(16'h8000, 16'h8000, 0);
    send_vector(16'h7fff, 16'h7fff, 0);
    send_vector(16'h8000, 16'h7fff, 0);
    send_vector(16'h7fff, 16'h8000, 0);
    send_vector(16'd1, 16'd1, 0);
    send_vector(16'hffff, 16'd1, 0);
    send_vector(16'd3, 16'd4, 0);
    send_vector(16'hfffd, 16'hfffc, 0);
    send_vector(16'd1, 16'h7fff, 0);
    send_vector(16'hffff, 16'h8000, 0);
    send_vector(16'd0, 16'd0, 0);
    send_vector(16'h5555, 16'haaaa, 0);
    send_vector(16'd1, 16'd2, 1);
    send_vector(16'd5, 16'd12, 1);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 400) long_stall = 1'b1;
      send_vector(rand_comp(), rand_comp(), 1);
    end
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < 2 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    $display("Sent %0d vectors (corners, zero, full scale, random), checked %0d results.",
             sent, board.matched);
    if (board.fails == 0 && board.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/vn_pkg.sv
hw/rtl/vn_lane.sv
hw/rtl/vector2_normalize_top.sv
sim/testbench.sv
